// File: design/etfi_pkg.sv
// shared types and constants of the escape-time fractal iterator
package etfi_pkg;

    localparam int DEF_COORD_BITS     = 32;
    localparam int DEF_ITER_BITS      = 16;
    localparam int DEF_FIRST_SAVE_MASK = 1;
    localparam int DEF_NEXT_SAVE_INCR = 4;

    localparam int ROW_BACKOFF    = 255;
    localparam int PERIOD_COLOR   = 7;
    localparam int ESCAPE_BACKOFF = 10;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRACTAL_KIND = 3'd0,
        REG_MAX_ITER     = 3'd1,
        REG_BAILOUT_SQ   = 3'd2,
        REG_PARAM_X      = 3'd3,
        REG_PARAM_Y      = 3'd4,
        REG_CLOSE_ENOUGH = 3'd5,
        REG_PERIOD_MODE  = 3'd6,
        REG_INSIDE_COLOR = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        OUTCOME_ESCAPED  = 2'd0,
        OUTCOME_MAX_ITER = 2'd1,
        OUTCOME_PERIODIC = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        PMODE_OFF    = 2'd0,
        PMODE_COLOR7 = 2'd1
    } pmode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_EVAL,
        ST_STEP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_JULIA,
        PH_START,
        PH_LOOP
    } phase_t;

endpackage

// File: design/etfi_pixel_if.sv
// pixel request channel
interface etfi_pixel_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic                         row_start;

    modport source (output valid, start_x, start_y, row_start, input ready);
    modport sink (input valid, start_x, start_y, row_start, output ready);
endinterface

// File: design/etfi_result_if.sv
// result channel
interface etfi_result_if #(
    parameter int ITER_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [ITER_BITS-1:0] color;
    logic [ITER_BITS-1:0] iter_count;
    logic [1:0]           outcome;

    modport source (output valid, color, iter_count, outcome, input ready);
    modport sink (input valid, color, iter_count, outcome, output ready);
endinterface

// File: design/escape_time_fractal_iterator.sv
// escape-time fractal iterator: one shared multiplier under a small sequencer
// a pixel runs ST_INIT, then per iteration ST_MUL_XX, ST_MUL_YY, ST_MUL_XY, ST_EVAL and ST_STEP, then ST_OUT
// julia mode adds a pass through the multiply states and ST_EVAL; x*x, y*y, x*y share one multiplier
// throughput: one pixel at a time, next pixel accepted once the result is registered
// reset: rst_n asynchronous active low, registers to their defaults, threshold to zero
module escape_time_fractal_iterator
    import etfi_pkg::*;
#(
    parameter int COORD_BITS      = DEF_COORD_BITS,
    parameter int ITER_BITS       = DEF_ITER_BITS,
    parameter int FIRST_SAVE_MASK = DEF_FIRST_SAVE_MASK,
    parameter int NEXT_SAVE_INCR  = DEF_NEXT_SAVE_INCR
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS+3:0]       cfg_data,
    etfi_pixel_if.sink                  pixel,
    etfi_result_if.source               result
);

    localparam int CB   = COORD_BITS;
    localparam int MB   = COORD_BITS + 4;
    localparam int SW   = MB + 2;
    localparam int FRAC = COORD_BITS - 4;
    localparam int IW   = ITER_BITS;
    localparam int TW   = ITER_BITS + 2;
    localparam int LW   = $clog2(NEXT_SAVE_INCR + 1);

    // configuration
    logic                 kind_reg;
    logic [IW-1:0]        max_iter_reg;
    logic [MB-1:0]        bailout_reg;
    logic signed [CB-1:0] param_x_reg;
    logic signed [CB-1:0] param_y_reg;
    logic [CB-2:0]        close_reg;
    logic [1:0]           pmode_reg;
    logic [IW-1:0]        inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= 1'b0;
            max_iter_reg <= IW'(255);
            bailout_reg  <= MB'(64'd1 << 30);
            param_x_reg  <= '0;
            param_y_reg  <= '0;
            close_reg    <= '0;
            pmode_reg    <= 2'd2;
            inside_reg   <= IW'(255);
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FRACTAL_KIND: kind_reg     <= cfg_data[0];
                REG_MAX_ITER:     max_iter_reg <= cfg_data[IW-1:0];
                REG_BAILOUT_SQ:   bailout_reg  <= cfg_data[MB-1:0];
                REG_PARAM_X:      param_x_reg  <= cfg_data[CB-1:0];
                REG_PARAM_Y:      param_y_reg  <= cfg_data[CB-1:0];
                REG_CLOSE_ENOUGH: close_reg    <= cfg_data[CB-2:0];
                REG_PERIOD_MODE:  pmode_reg    <= cfg_data[1:0];
                REG_INSIDE_COLOR: inside_reg   <= cfg_data[IW-1:0];
                default:          kind_reg     <= kind_reg;
            endcase
        end
    end

    // datapath registers
    state_t state_reg, state_next;
    phase_t phase_reg;
    logic signed [CB-1:0] x_reg, y_reg, cre_reg, cim_reg, sx_reg, sy_reg;
    logic signed [MB-1:0] x2_reg, y2_reg, xy_reg;
    logic [IW-1:0]        cnt_reg, th_reg, mask_reg, pthr_reg;
    logic [LW-1:0]        left_reg;
    logic [IW-1:0]        res_color_reg, res_iter_reg;
    logic [1:0]           res_outcome_reg;
    logic                 ovalid_reg;
    logic [IW-1:0]        ocolor_reg, oiter_reg;
    logic [1:0]           ooutcome_reg;

    // shared multiplier, floored to the square format
    logic signed [CB-1:0]   mul_a, mul_b;
    logic signed [2*CB-1:0] prod;
    logic signed [MB-1:0]   prod_q;

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_XX: begin mul_a = x_reg; mul_b = x_reg; end
            ST_MUL_YY: begin mul_a = y_reg; mul_b = y_reg; end
            default:   begin mul_a = x_reg; mul_b = y_reg; end
        endcase
        prod   = mul_a * mul_b;
        prod_q = prod[2*CB-1:FRAC];
    end

    // shared adder with saturation to the coordinate format
    logic signed [SW-1:0] sum_re, sum_im;
    logic signed [CB-1:0] sat_re, sat_im;
    logic signed [CB-1:0] max_c, min_c;

    always_comb
    begin
        max_c = {1'b0, {(CB-1){1'b1}}};
        min_c = {1'b1, {(CB-1){1'b0}}};
        if (state_reg == ST_INIT)
        begin
            sum_re = SW'(param_x_reg) + SW'(x_reg);
            sum_im = SW'(param_y_reg) + SW'(y_reg);
        end
        else
        begin
            sum_re = SW'(x2_reg) - SW'(y2_reg) + SW'(cre_reg);
            sum_im = (SW'(xy_reg) <<< 1) + SW'(cim_reg);
        end
        if (sum_re[SW-1:CB-1] != {(SW-CB+1){sum_re[SW-1]}})
            sat_re = sum_re[SW-1] ? min_c : max_c;
        else
            sat_re = sum_re[CB-1:0];
        if (sum_im[SW-1:CB-1] != {(SW-CB+1){sum_im[SW-1]}})
            sat_im = sum_im[SW-1] ? min_c : max_c;
        else
            sat_im = sum_im[CB-1:0];
    end

    // threshold at pixel start
    logic signed [TW-1:0] th_sel, th_lim, th_min;
    logic [IW-1:0]        th_start;

    always_comb
    begin
        if (pmode_reg == PMODE_OFF)
            th_sel = '0;
        else if (pixel.row_start)
            th_sel = TW'(max_iter_reg) - TW'(ROW_BACKOFF);
        else
            th_sel = TW'(pthr_reg);
        th_lim = TW'(max_iter_reg) - TW'(FIRST_SAVE_MASK);
        th_min = (th_sel > th_lim) ? th_lim : th_sel;
        th_start = th_min[TW-1] ? '0 : th_min[IW-1:0];
    end

    // escape and periodicity tests
    logic [MB:0]        mag_sum;
    logic [MB-1:0]      mag;
    logic               escaped;
    logic signed [CB:0] dx, dy;
    logic [CB:0]        adx, ady;
    logic               close_hit;
    logic [IW-1:0]      done_cnt;
    logic               save_slot;

    always_comb
    begin
        mag_sum   = {1'b0, x2_reg[MB-1:0]} + {1'b0, y2_reg[MB-1:0]};
        mag       = mag_sum[MB] ? {MB{1'b1}} : mag_sum[MB-1:0];
        escaped   = mag >= bailout_reg;
        dx        = (CB+1)'(sx_reg) - (CB+1)'(x_reg);
        dy        = (CB+1)'(sy_reg) - (CB+1)'(y_reg);
        adx       = dx[CB] ? (CB+1)'(-dx) : dx[CB:0];
        ady       = dy[CB] ? (CB+1)'(-dy) : dy[CB:0];
        close_hit = (adx < (CB+1)'(close_reg)) && (ady < (CB+1)'(close_reg));
        done_cnt  = max_iter_reg - cnt_reg;
        save_slot = (done_cnt & mask_reg) == '0;
    end

    logic out_free;
    assign out_free     = !ovalid_reg || result.ready;
    assign pixel.ready  = (state_reg == ST_IDLE);
    assign result.valid = ovalid_reg;
    assign result.color = ocolor_reg;
    assign result.iter_count = oiter_reg;
    assign result.outcome = ooutcome_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (pixel.valid) state_next = ST_INIT;
            ST_INIT:   state_next = ST_MUL_XX;
            ST_MUL_XX: state_next = ST_MUL_YY;
            ST_MUL_YY: state_next = ST_MUL_XY;
            ST_MUL_XY: state_next = ST_EVAL;
            ST_EVAL:
            begin
                priority case (phase_reg)
                    PH_JULIA: state_next = ST_MUL_XX;
                    PH_START: state_next = ST_STEP;
                    default:
                    begin
                        if (escaped)
                            state_next = ST_OUT;
                        else if (cnt_reg < th_reg && !save_slot && close_hit)
                            state_next = ST_OUT;
                        else
                            state_next = ST_STEP;
                    end
                endcase
            end
            ST_STEP:   state_next = (cnt_reg <= IW'(1)) ? ST_OUT : ST_MUL_XX;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pthr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (result.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_EVAL && phase_reg == PH_LOOP)
            begin
                if (escaped)
                    pthr_reg <= (cnt_reg > IW'(ESCAPE_BACKOFF)) ?
                                cnt_reg - IW'(ESCAPE_BACKOFF) : '0;
                else if (cnt_reg < th_reg && !save_slot && close_hit)
                    pthr_reg <= max_iter_reg;
            end
            else if (state_reg == ST_STEP && cnt_reg <= IW'(1))
                pthr_reg <= max_iter_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                th_reg   <= th_start;
                mask_reg <= IW'(FIRST_SAVE_MASK);
                left_reg <= LW'(1);
                sx_reg   <= '0;
                sy_reg   <= '0;
                x_reg    <= pixel.start_x;
                y_reg    <= pixel.start_y;
            end
            ST_INIT:
            begin
                if (!kind_reg)
                begin
                    x_reg     <= sat_re;
                    y_reg     <= sat_im;
                    cre_reg   <= x_reg;
                    cim_reg   <= y_reg;
                    phase_reg <= PH_START;
                end
                else
                begin
                    cre_reg   <= param_x_reg;
                    cim_reg   <= param_y_reg;
                    phase_reg <= PH_JULIA;
                end
            end
            ST_MUL_XX: x2_reg <= prod_q;
            ST_MUL_YY: y2_reg <= prod_q;
            ST_MUL_XY: xy_reg <= prod_q;
            ST_EVAL:
            begin
                priority case (phase_reg)
                    PH_JULIA:
                    begin
                        x_reg     <= sat_re;
                        y_reg     <= sat_im;
                        phase_reg <= PH_START;
                    end
                    PH_START: cnt_reg <= max_iter_reg;
                    default:
                    begin
                        if (escaped)
                        begin
                            res_color_reg   <= (done_cnt == '0) ? IW'(1) : done_cnt;
                            res_iter_reg    <= done_cnt;
                            res_outcome_reg <= OUTCOME_ESCAPED;
                        end
                        else if (cnt_reg < th_reg)
                        begin
                            if (save_slot)
                            begin
                                sx_reg <= x_reg;
                                sy_reg <= y_reg;
                                if (left_reg == LW'(1))
                                begin
                                    mask_reg <= {mask_reg[IW-2:0], 1'b1};
                                    left_reg <= LW'(NEXT_SAVE_INCR);
                                end
                                else
                                    left_reg <= left_reg - LW'(1);
                            end
                            else if (close_hit)
                            begin
                                res_color_reg   <= (pmode_reg == PMODE_COLOR7) ?
                                                   IW'(PERIOD_COLOR) : inside_reg;
                                res_iter_reg    <= max_iter_reg;
                                res_outcome_reg <= OUTCOME_PERIODIC;
                            end
                        end
                    end
                endcase
            end
            ST_STEP:
            begin
                if (cnt_reg <= IW'(1))
                begin
                    res_color_reg   <= inside_reg;
                    res_iter_reg    <= max_iter_reg;
                    res_outcome_reg <= OUTCOME_MAX_ITER;
                end
                else
                begin
                    cnt_reg   <= cnt_reg - IW'(1);
                    x_reg     <= sat_re;
                    y_reg     <= sat_im;
                    phase_reg <= PH_LOOP;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ocolor_reg   <= res_color_reg;
                    oiter_reg    <= res_iter_reg;
                    ooutcome_reg <= res_outcome_reg;
                end
            end
            default: cnt_reg <= cnt_reg;
        endcase
    end

endmodule

// File: test/etfi_tb_checker.sv
// checker: predicts each pixel's color, iteration count and outcome from the observed requests and compares results
module etfi_tb_checker
    import etfi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data,
    etfi_pixel_if       pixel,
    etfi_result_if      result,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] color;
        logic [15:0] iter_count;
        outcome_t    outcome;
    } pixel_color_t;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint MAG_MAX   = 64'sd68719476735;

    logic               kind;
    logic [15:0]        max_iter;
    logic [35:0]        bailout_sq;
    logic signed [31:0] param_x;
    logic signed [31:0] param_y;
    logic [30:0]        close_enough;
    logic [1:0]         pmode;
    logic [15:0]        inside_color;
    logic [15:0]        period_threshold;

    pixel_color_t expected_colors[$];

    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic longint mul_q28(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 28;
    endfunction

    function automatic void color_pixel(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic row, output pixel_color_t r);
        int          mi, th, lim, cnt, done;
        longint      x, y, cre, cim, x2, y2, xy, sxv, syv, dx, dy, mag;
        int unsigned save_mask;
        int          save_left;
        logic [15:0] pcolor;
        mi = int'(max_iter);
        save_mask = DEF_FIRST_SAVE_MASK;
        save_left = 1;
        sxv = 0;
        syv = 0;
        pcolor = (pmode == PMODE_COLOR7) ? 16'(PERIOD_COLOR) : inside_color;
        if (pmode == PMODE_OFF)
            th = 0;
        else if (row)
            th = mi - ROW_BACKOFF;
        else
            th = int'(period_threshold);
        lim = mi - DEF_FIRST_SAVE_MASK;
        if (th > lim)
            th = lim;
        if (th < 0)
            th = 0;
        if (kind == 1'b0)
        begin
            cre = longint'(px);
            cim = longint'(py);
            x = sat_coord(longint'(param_x) + cre);
            y = sat_coord(longint'(param_y) + cim);
        end
        else
        begin
            cre = longint'(param_x);
            cim = longint'(param_y);
            x2 = mul_q28(px, px);
            y2 = mul_q28(py, py);
            xy = mul_q28(px, py);
            x = sat_coord(x2 - y2 + cre);
            y = sat_coord(2 * xy + cim);
        end
        x2 = mul_q28(x, x);
        y2 = mul_q28(y, y);
        xy = mul_q28(x, y);
        cnt = mi;
        while (--cnt > 0)
        begin
            x = sat_coord(x2 - y2 + cre);
            y = sat_coord(2 * xy + cim);
            x2 = mul_q28(x, x);
            y2 = mul_q28(y, y);
            xy = mul_q28(x, y);
            mag = x2 + y2;
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            if (mag >= longint'({28'b0, bailout_sq}))
            begin
                done = mi - cnt;
                period_threshold = (cnt - ESCAPE_BACKOFF > 0) ?
                                   16'(cnt - ESCAPE_BACKOFF) : 16'd0;
                r.color = (done == 0) ? 16'd1 : 16'(done);
                r.iter_count = 16'(done);
                r.outcome = OUTCOME_ESCAPED;
                return;
            end
            if (cnt < th)
            begin
                if ((unsigned'(mi - cnt) & save_mask) == 0)
                begin
                    sxv = x;
                    syv = y;
                    if (--save_left == 0)
                    begin
                        save_mask = (save_mask << 1) + 1;
                        save_left = DEF_NEXT_SAVE_INCR;
                    end
                end
                else
                begin
                    dx = sxv - x;
                    dy = syv - y;
                    if (dx < 0)
                        dx = -dx;
                    if (dy < 0)
                        dy = -dy;
                    if (dx < longint'(close_enough) && dy < longint'(close_enough))
                    begin
                        period_threshold = 16'(mi);
                        r.color = pcolor;
                        r.iter_count = 16'(mi);
                        r.outcome = OUTCOME_PERIODIC;
                        return;
                    end
                end
            end
        end
        period_threshold = 16'(mi);
        r.color = inside_color;
        r.iter_count = 16'(mi);
        r.outcome = OUTCOME_MAX_ITER;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_color_t p, got;
        if (!rst_n)
        begin
            kind = 1'b0;
            max_iter = 16'd255;
            bailout_sq = 36'd1 << 30;
            param_x = '0;
            param_y = '0;
            close_enough = '0;
            pmode = 2'd2;
            inside_color = 16'd255;
            period_threshold = '0;
            fail_count = 0;
            expected_colors.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FRACTAL_KIND: kind = cfg_data[0];
                    REG_MAX_ITER:     max_iter = cfg_data[15:0];
                    REG_BAILOUT_SQ:   bailout_sq = cfg_data;
                    REG_PARAM_X:      param_x = cfg_data[31:0];
                    REG_PARAM_Y:      param_y = cfg_data[31:0];
                    REG_CLOSE_ENOUGH: close_enough = cfg_data[30:0];
                    REG_PERIOD_MODE:  pmode = cfg_data[1:0];
                    REG_INSIDE_COLOR: inside_color = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (pixel.valid && pixel.ready)
            begin
                color_pixel(pixel.start_x, pixel.start_y, pixel.row_start, p);
                expected_colors.push_back(p);
            end
            if (result.valid && result.ready)
            begin
                got.color = result.color;
                got.iter_count = result.iter_count;
                got.outcome = outcome_t'(result.outcome);
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result color=%0d iter=%0d outcome=%0d",
                                 got.color, got.iter_count, got.outcome);
                end
                else
                begin
                    p = expected_colors.pop_front();
                    if (got !== p)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected color=%0d iter=%0d outcome=%0d,",
                                     p.color, p.iter_count, p.outcome,
                                     " got color=%0d iter=%0d outcome=%0d",
                                     got.color, got.iter_count, got.outcome);
                    end
                end
            end
        end
        pending = expected_colors.size();
    end

endmodule

// File: test/tb.sv
// testbench top: drives pixel requests and register writes, gives the verdict
module tb
    import etfi_pkg::*;
();

    localparam int CYCLE_LIMIT = 40000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [35:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          no_idle;

    etfi_pixel_if  #(.COORD_BITS(32)) pixel_ch();
    etfi_result_if #(.ITER_BITS(16))  result_ch();

    escape_time_fractal_iterator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    etfi_tb_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // result side: random stall before each result, none while no_idle is set
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic send_pixel(input logic [31:0] x, input logic [31:0] y, input logic row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.start_x <= x;
        pixel_ch.start_y <= y;
        pixel_ch.row_start <= row;
        do @(posedge clk); while (!(pixel_ch.valid && pixel_ch.ready));
        @(negedge clk);
    endtask

    task automatic drain;
        pixel_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [35:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            default: return 32'($signed($urandom_range(0, 1342177280)) - 671088640);
        endcase
    endfunction

    task automatic rand_config(input bit big);
        write_reg(REG_FRACTAL_KIND, 36'($urandom_range(0, 1)));
        if (big)
            write_reg(REG_MAX_ITER, 36'd65535);
        else
            write_reg(REG_MAX_ITER, 36'($urandom_range(0, 300)));
        case ($urandom_range(0, 4))
            0:       write_reg(REG_BAILOUT_SQ, 36'd0);
            1:       write_reg(REG_BAILOUT_SQ, 36'hFFFFFFFFF);
            2:       write_reg(REG_BAILOUT_SQ, 36'({$urandom, $urandom}));
            default: write_reg(REG_BAILOUT_SQ, 36'd1 << 30);
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_PARAM_X, 36'($urandom));
            write_reg(REG_PARAM_Y, 36'($urandom));
        end
        else
        begin
            write_reg(REG_PARAM_X, 36'(rand_coord()) & 36'hFFFFFFFF);
            write_reg(REG_PARAM_Y, 36'(rand_coord()) & 36'hFFFFFFFF);
        end
        case ($urandom_range(0, 2))
            0:       write_reg(REG_CLOSE_ENOUGH, 36'd0);
            1:       write_reg(REG_CLOSE_ENOUGH, 36'($urandom_range(0, 1 << 20)));
            default: write_reg(REG_CLOSE_ENOUGH, 36'($urandom) & 36'h7FFFFFFF);
        endcase
        write_reg(REG_PERIOD_MODE, 36'($urandom_range(0, 3)));
        write_reg(REG_INSIDE_COLOR, 36'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.start_x = '0;
        pixel_ch.start_y = '0;
        pixel_ch.row_start = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: defaults, field extremes
        send_pixel(32'h0, 32'h0, 1'b1);
        send_pixel(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_pixel(32'h80000000, 32'h80000000, 1'b0);
        send_pixel(32'h80000000, 32'h7FFFFFFF, 1'b1);
        send_pixel(32'hF8000000, 32'h0, 1'b0);
        drain();
        // periodicity with color 7 and a wide tolerance
        write_reg(REG_PERIOD_MODE, 36'd1);
        write_reg(REG_CLOSE_ENOUGH, 36'h7FFFFFFF);
        write_reg(REG_INSIDE_COLOR, 36'hFFFF);
        write_reg(REG_BAILOUT_SQ, 36'hFFFFFFFFF);
        send_pixel(32'h0, 32'h0, 1'b1);
        send_pixel(32'hF0000000, 32'h0, 1'b0);
        send_pixel(32'h0, 32'h0, 1'b0);
        drain();
        // julia start, mode three, parameter extremes
        write_reg(REG_FRACTAL_KIND, 36'd1);
        write_reg(REG_PERIOD_MODE, 36'd3);
        write_reg(REG_PARAM_X, 36'h80000000);
        write_reg(REG_PARAM_Y, 36'h7FFFFFFF);
        write_reg(REG_BAILOUT_SQ, 36'd1 << 30);
        send_pixel(32'h0, 32'h0, 1'b1);
        send_pixel(32'h7FFFFFFF, 32'h80000000, 1'b0);
        drain();
        write_reg(REG_PARAM_X, 36'h0);
        write_reg(REG_PARAM_Y, 36'h0);
        write_reg(REG_CLOSE_ENOUGH, 36'd1000);
        send_pixel(32'h08000000, 32'h0, 1'b1);
        send_pixel(32'h10000000, 32'h0, 1'b0);
        drain();
        // small budgets and zero bailout
        write_reg(REG_MAX_ITER, 36'd0);
        send_pixel(32'h0, 32'h0, 1'b0);
        drain();
        write_reg(REG_MAX_ITER, 36'd1);
        send_pixel(32'h0, 32'h0, 1'b1);
        drain();
        write_reg(REG_MAX_ITER, 36'd2);
        write_reg(REG_BAILOUT_SQ, 36'd0);
        send_pixel(32'h0, 32'h0, 1'b0);
        drain();
        write_reg(REG_FRACTAL_KIND, 36'd0);
        send_pixel(32'h0, 32'h0, 1'b1);
        drain();
        // largest budget, points that escape or settle quickly
        write_reg(REG_MAX_ITER, 36'd65535);
        write_reg(REG_BAILOUT_SQ, 36'd1 << 30);
        write_reg(REG_PERIOD_MODE, 36'd2);
        write_reg(REG_CLOSE_ENOUGH, 36'd1 << 24);
        send_pixel(32'h0, 32'h0, 1'b1);
        send_pixel(32'h20000000, 32'h20000000, 1'b0);
        send_pixel(32'hFC000000, 32'h0, 1'b0);
        drain();
        write_reg(REG_PERIOD_MODE, 36'd0);
        send_pixel(32'h30000000, 32'h0, 1'b0);
        drain();

        // random phases
        n = 0;
        for (int ph = 0; ph < 14; ph++)
        begin
            rand_config(1'b0);
            no_idle = (ph % 5 == 2);
            for (int i = 0; i < 38; i++)
            begin
                send_pixel(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0));
                n++;
                if (n == 100)
                begin
                    pixel_ch.valid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
            end
            drain();
        end
        no_idle = 1'b0;
        rand_config(1'b1);
        write_reg(REG_PERIOD_MODE, 36'd1);
        write_reg(REG_CLOSE_ENOUGH, 36'd1 << 26);
        write_reg(REG_BAILOUT_SQ, 36'd1 << 30);
        for (int i = 0; i < 6; i++)
            send_pixel($urandom, $urandom, 1'b1);
        drain();
        write_reg(REG_FRACTAL_KIND, 36'd0);
        write_reg(REG_MAX_ITER, 36'd255);
        write_reg(REG_PARAM_X, 36'h0);
        write_reg(REG_PARAM_Y, 36'h0);
        write_reg(REG_PERIOD_MODE, 36'd2);
        write_reg(REG_INSIDE_COLOR, 36'd0);
        for (int i = 0; i < 10; i++)
            send_pixel(rand_coord(), rand_coord(), ($urandom_range(0, 3) == 0));
        drain();

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: filelist.f
design/etfi_pkg.sv
design/etfi_pixel_if.sv
design/etfi_result_if.sv
design/escape_time_fractal_iterator.sv
test/etfi_tb_checker.sv
test/tb.sv
